@@ design/wma_pkg.sv @@
// Shared types, constants and codes of the waveform moment accumulator.
// Used by every module of the block; depends on nothing else.
package wma_pkg;

  // Default sizes of the statistics stores.
  localparam int MAX_CHANNELS_DEFAULT = 256;
  localparam int MAX_SAMPLES_DEFAULT  = 64;

  // Widths of the port fields.
  localparam int CMD_W     = 2;
  localparam int CHANNEL_W = 8;
  localparam int INDEX_W   = 6;
  localparam int VALUE_W   = 16;
  localparam int KIND_W    = 2;
  localparam int DATA_W    = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;
  localparam int SCOUNT_W  = 7;
  localparam int CCOUNT_W  = 9;

  // Width used for range checks against the configured counts.
  localparam int CMPW = 16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ACCUMULATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ       = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 2'd2;

  // Read selectors.
  localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUM    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUMSQ  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PAIR   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COV_ENABLE    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [SCOUNT_W-1:0] SAMPLE_COUNT_RESET  = 7'd64;
  localparam logic [CCOUNT_W-1:0] CHANNEL_COUNT_RESET = 9'd256;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_COV,
    ST_DRAIN_A,
    ST_DRAIN_B,
    ST_RD_ADDR,
    ST_RD_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic acc_write;
    logic cov_issue;
    logic clear_en;
    logic read_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             acc_ok;
    logic             cov_run;
    logic             issue_last;
    logic             clear_last;
  } ctrl_status_t;

endpackage

@@ design/waveform_moment_accumulator_unit.sv @@
// Top level of the waveform moment accumulator.
// Joins wma_ctrl and wma_datapath; depends on wma_pkg.
//
// The block keeps, per channel, an event count and, per channel and sample
// position, a 64-bit wrapping sum and sum of squares of unsigned 16-bit
// samples, plus optional pairwise product sums. A beat is taken when start is
// high and busy is low. A read answers with read_data and error on a done
// strobe that lasts one cycle and cannot be held off, so the receiver must
// take it then. A read passes through its decode, address and output states
// before its done strobe. An accumulate reads and then writes back its
// stores; with products enabled and a nonzero sample index, a pair loop then
// reads one buffered sample and one pair sum per cycle through a single
// memory port and feeds a three-stage multiply-add pipeline, which drains
// before busy falls. A dropped accumulate returns to idle from decode.
// A clear command, and reset itself, start a clearing pass that walks one
// address over the larger of the pair store and the sample stores and zeroes
// the event, sum, square and pair entries at that address while it lies
// in each store's range; busy stays high meanwhile. Configuration writes
// are taken on any cycle but must only be made while idle.
module waveform_moment_accumulator_unit #(
  parameter int MAX_CHANNELS = wma_pkg::MAX_CHANNELS_DEFAULT,
  parameter int MAX_SAMPLES  = wma_pkg::MAX_SAMPLES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [wma_pkg::CMD_W-1:0]     command,
  input  logic [wma_pkg::CHANNEL_W-1:0] channel,
  input  logic [wma_pkg::INDEX_W-1:0]   sample_index,
  input  logic [wma_pkg::VALUE_W-1:0]   sample_value,
  input  logic [wma_pkg::KIND_W-1:0]    stat_kind,
  input  logic [wma_pkg::INDEX_W-1:0]   second_index,
  input  logic                          cfg_write,
  input  logic [wma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wma_pkg::CFG_DAT_W-1:0] cfg_data,
  output logic                          done,
  output logic [wma_pkg::DATA_W-1:0]    read_data,
  output logic                          error
);

  // Command and status bundles between the sequencer and the datapath.
  wma_pkg::ctrl_cmd_t    cmd;
  wma_pkg::ctrl_status_t status;

  wma_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  wma_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_SAMPLES  (MAX_SAMPLES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .command      (command),
    .channel      (channel),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .stat_kind    (stat_kind),
    .second_index (second_index),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .read_data    (read_data),
    .error        (error),
    .done         (done)
  );

endmodule

@@ design/wma_ctrl.sv @@
// Sequencer of the waveform moment accumulator.
// Depends on wma_pkg for the state, command and status types.
module wma_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  wma_pkg::ctrl_status_t status,
  output wma_pkg::ctrl_cmd_t    cmd
);

  wma_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wma_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wma_pkg::ST_CLEAR: begin
        if (status.clear_last) state_next = wma_pkg::ST_IDLE;
      end
      wma_pkg::ST_IDLE: begin
        if (start) state_next = wma_pkg::ST_DECODE;
      end
      wma_pkg::ST_DECODE: begin
        priority if (status.cmd == wma_pkg::CMD_ACCUMULATE) begin
          state_next = status.acc_ok ? wma_pkg::ST_ACC_RD : wma_pkg::ST_IDLE;
        end else if (status.cmd == wma_pkg::CMD_READ) begin
          state_next = wma_pkg::ST_RD_ADDR;
        end else if (status.cmd == wma_pkg::CMD_CLEAR) begin
          state_next = wma_pkg::ST_CLEAR;
        end else begin
          state_next = wma_pkg::ST_IDLE;
        end
      end
      wma_pkg::ST_ACC_RD:  state_next = wma_pkg::ST_ACC_WR;
      wma_pkg::ST_ACC_WR: begin
        state_next = status.cov_run ? wma_pkg::ST_COV : wma_pkg::ST_IDLE;
      end
      wma_pkg::ST_COV: begin
        if (status.issue_last) state_next = wma_pkg::ST_DRAIN_A;
      end
      wma_pkg::ST_DRAIN_A: state_next = wma_pkg::ST_DRAIN_B;
      wma_pkg::ST_DRAIN_B: state_next = wma_pkg::ST_IDLE;
      wma_pkg::ST_RD_ADDR: state_next = wma_pkg::ST_RD_OUT;
      wma_pkg::ST_RD_OUT:  state_next = wma_pkg::ST_IDLE;
      default:             state_next = wma_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state != wma_pkg::ST_IDLE);
    cmd.load      = (state == wma_pkg::ST_IDLE) && start;
    cmd.acc_write = (state == wma_pkg::ST_ACC_WR);
    cmd.cov_issue = (state == wma_pkg::ST_COV);
    cmd.clear_en  = (state == wma_pkg::ST_CLEAR);
    cmd.read_out  = (state == wma_pkg::ST_RD_OUT);
  end

endmodule

@@ design/wma_datapath.sv @@
// Datapath of the waveform moment accumulator: item and configuration
// registers, the statistics memories, the product pipeline and the read mux.
// Depends on wma_pkg.
module wma_datapath #(
  parameter int MAX_CHANNELS = wma_pkg::MAX_CHANNELS_DEFAULT,
  parameter int MAX_SAMPLES  = wma_pkg::MAX_SAMPLES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [wma_pkg::CMD_W-1:0]       command,
  input  logic [wma_pkg::CHANNEL_W-1:0]   channel,
  input  logic [wma_pkg::INDEX_W-1:0]     sample_index,
  input  logic [wma_pkg::VALUE_W-1:0]     sample_value,
  input  logic [wma_pkg::KIND_W-1:0]      stat_kind,
  input  logic [wma_pkg::INDEX_W-1:0]     second_index,
  input  logic                            cfg_write,
  input  logic [wma_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wma_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  wma_pkg::ctrl_cmd_t              cmd,
  output wma_pkg::ctrl_status_t           status,
  output logic [wma_pkg::DATA_W-1:0]      read_data,
  output logic                            error,
  output logic                            done
);

  localparam int SIW       = $clog2(MAX_SAMPLES);
  localparam int CHW       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PAIRS     = MAX_SAMPLES * (MAX_SAMPLES - 1) / 2;
  localparam int SS_DEPTH  = MAX_CHANNELS * MAX_SAMPLES;
  localparam int SSW       = $clog2(SS_DEPTH);
  localparam int PP_DEPTH  = MAX_CHANNELS * PAIRS;
  localparam int PPW       = (PP_DEPTH > 1) ? $clog2(PP_DEPTH) : 1;
  localparam int CLR_DEPTH = (PP_DEPTH > SS_DEPTH) ? PP_DEPTH : SS_DEPTH;
  localparam int CLRW      = $clog2(CLR_DEPTH);
  localparam int SLOTW     = 16;
  localparam int STEPW     = 8;
  localparam int CMPW      = wma_pkg::CMPW;
  localparam int DW        = wma_pkg::DATA_W;
  localparam int VW        = wma_pkg::VALUE_W;

  // Configuration registers.
  logic [wma_pkg::SCOUNT_W-1:0] sample_count;
  logic [wma_pkg::CCOUNT_W-1:0] channel_count;
  logic                         covariance_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count      <= wma_pkg::SAMPLE_COUNT_RESET;
      channel_count     <= wma_pkg::CHANNEL_COUNT_RESET;
      covariance_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wma_pkg::CFG_SAMPLE_COUNT:  sample_count <= cfg_data[wma_pkg::SCOUNT_W-1:0];
        wma_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg_data;
        wma_pkg::CFG_COV_ENABLE:    covariance_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Latched item.
  logic [wma_pkg::CMD_W-1:0]     cmd_r;
  logic [wma_pkg::CHANNEL_W-1:0] ch_r;
  logic [wma_pkg::INDEX_W-1:0]   si_r;
  logic [VW-1:0]                 v_r;
  logic [wma_pkg::KIND_W-1:0]    kind_r;
  logic [wma_pkg::INDEX_W-1:0]   sj_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= command;
      ch_r   <= channel;
      si_r   <= sample_index;
      v_r    <= sample_value;
      kind_r <= stat_kind;
      sj_r   <= second_index;
    end
  end

  // Range checks against the effective counts.
  logic [CMPW-1:0] ns, nc;
  logic            ch_bad, si_bad, pair_ok, is_last, rd_err;

  always_comb begin
    ns = (CMPW'(sample_count) > CMPW'(MAX_SAMPLES)) ? CMPW'(MAX_SAMPLES)
                                                    : CMPW'(sample_count);
    nc = (CMPW'(channel_count) > CMPW'(MAX_CHANNELS)) ? CMPW'(MAX_CHANNELS)
                                                      : CMPW'(channel_count);
    ch_bad  = CMPW'(ch_r) >= nc;
    si_bad  = CMPW'(si_r) >= ns;
    pair_ok = (si_r < sj_r) && (CMPW'(sj_r) < ns);
    is_last = (CMPW'(si_r) + CMPW'(1)) == ns;
    if (ch_bad) begin
      rd_err = 1'b1;
    end else if (kind_r == wma_pkg::KIND_COUNT) begin
      rd_err = 1'b0;
    end else if (kind_r == wma_pkg::KIND_PAIR) begin
      rd_err = !pair_ok;
    end else begin
      rd_err = si_bad;
    end
  end

  // Address and square products, registered in the cycle after the item is latched.
  logic [SSW-1:0]   base_q;
  logic [PPW-1:0]   pair_chan_q;
  logic [SLOTW-1:0] slot_prod_q;
  logic [2*VW-1:0]  vsq_q;

  always_ff @(posedge clk) begin
    base_q      <= SSW'(32'(ch_r) * MAX_SAMPLES + 32'(si_r));
    pair_chan_q <= PPW'(32'(ch_r) * PAIRS);
    slot_prod_q <= SLOTW'(32'(si_r) * (32'(2 * MAX_SAMPLES - 1) - 32'(si_r)));
    vsq_q       <= 32'(v_r) * 32'(v_r);
  end

  logic [PPW-1:0] rd_pair_addr;
  assign rd_pair_addr = pair_chan_q + PPW'(slot_prod_q >> 1) + PPW'(sj_r)
                      - PPW'(si_r) - PPW'(1);

  // Clearing sweep.
  logic [CLRW-1:0] clr_addr;
  logic            clr_ss, clr_pp, clr_ev;

  always_ff @(posedge clk) begin
    if (rst || !cmd.clear_en) begin
      clr_addr <= '0;
    end else begin
      clr_addr <= clr_addr + CLRW'(1);
    end
  end

  assign clr_ss = cmd.clear_en && (32'(clr_addr) < SS_DEPTH);
  assign clr_pp = cmd.clear_en && (32'(clr_addr) < PP_DEPTH);
  assign clr_ev = cmd.clear_en && (32'(clr_addr) < MAX_CHANNELS);

  // Pair loop walk: the slot of pair (j, i) advances by MAX_SAMPLES-2-j.
  logic [SIW-1:0]   j_cnt;
  logic [STEPW-1:0] step;
  logic [PPW-1:0]   cov_addr;

  always_ff @(posedge clk) begin
    if (cmd.acc_write) begin
      j_cnt    <= '0;
      step     <= STEPW'(MAX_SAMPLES - 2);
      cov_addr <= pair_chan_q + PPW'(si_r) - PPW'(1);
    end else if (cmd.cov_issue) begin
      j_cnt    <= j_cnt + SIW'(1);
      step     <= step - STEPW'(1);
      cov_addr <= cov_addr + PPW'(step);
    end
  end

  // Memories.
  logic [DW-1:0] ev_mem  [MAX_CHANNELS];
  logic [DW-1:0] ss_mem  [SS_DEPTH];
  logic [DW-1:0] sq_mem  [SS_DEPTH];
  logic [DW-1:0] pp_mem  [PP_DEPTH];
  logic [VW-1:0] buf_mem [MAX_SAMPLES];

  logic [DW-1:0] ev_q, ss_q, sq_q, pp_q;
  logic [VW-1:0] buf_q;

  always_ff @(posedge clk) begin
    if (clr_ev) begin
      ev_mem[CHW'(clr_addr)] <= '0;
    end else if (cmd.acc_write && is_last) begin
      ev_mem[CHW'(ch_r)] <= ev_q + DW'(1);
    end
    ev_q <= ev_mem[CHW'(ch_r)];
  end

  always_ff @(posedge clk) begin
    if (clr_ss) begin
      ss_mem[SSW'(clr_addr)] <= '0;
    end else if (cmd.acc_write) begin
      ss_mem[base_q] <= ss_q + DW'(v_r);
    end
    ss_q <= ss_mem[base_q];
  end

  always_ff @(posedge clk) begin
    if (clr_ss) begin
      sq_mem[SSW'(clr_addr)] <= '0;
    end else if (cmd.acc_write) begin
      sq_mem[base_q] <= sq_q + DW'(vsq_q);
    end
    sq_q <= sq_mem[base_q];
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_write) begin
      buf_mem[SIW'(si_r)] <= v_r;
    end
    buf_q <= buf_mem[j_cnt];
  end

  // Product pipeline: read, multiply, write back.
  logic            s1_valid, s2_valid;
  logic [PPW-1:0]  s1_addr, s2_addr;
  logic [2*VW-1:0] s2_prod;
  logic [DW-1:0]   s2_old;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.cov_issue;
      s2_valid <= s1_valid;
    end
    s1_addr <= cov_addr;
    s2_addr <= s1_addr;
    s2_prod <= 32'(buf_q) * 32'(v_r);
    s2_old  <= pp_q;
  end

  always_ff @(posedge clk) begin
    if (clr_pp) begin
      pp_mem[PPW'(clr_addr)] <= '0;
    end else if (s2_valid) begin
      pp_mem[s2_addr] <= s2_old + DW'(s2_prod);
    end
    pp_q <= pp_mem[cmd.cov_issue ? cov_addr : rd_pair_addr];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.read_out;
    end
    if (cmd.read_out) begin
      error <= rd_err;
      if (rd_err) begin
        read_data <= '0;
      end else begin
        unique case (kind_r)
          wma_pkg::KIND_COUNT: read_data <= ev_q;
          wma_pkg::KIND_SUM:   read_data <= ss_q;
          wma_pkg::KIND_SUMSQ: read_data <= sq_q;
          wma_pkg::KIND_PAIR:  read_data <= pp_q;
          default:             read_data <= '0;
        endcase
      end
    end
  end

  always_comb begin
    status.cmd        = cmd_r;
    status.acc_ok     = !ch_bad && !si_bad;
    status.cov_run    = covariance_enable && (si_r != '0);
    status.issue_last = (STEPW'(j_cnt) + STEPW'(1)) == STEPW'(si_r);
    status.clear_last = clr_addr == CLRW'(CLR_DEPTH - 1);
  end

endmodule

@@ design/wma_checker.sv @@
// Port-level checks of the waveform moment accumulator and their binding.
// Depends on waveform_moment_accumulator_unit and wma_pkg.
module wma_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic                       error,
  input logic [wma_pkg::DATA_W-1:0] read_data
);

  // An accepted beat always occupies the block on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");

  // Each read passes through its decode and address states before its output state, so strobes never come back to back.
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("two result beats in a row");

  // A result only follows a cycle of work.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result beat without preceding work");

  // Errored reads return zero data.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> (read_data == '0)) else $error("error result with data");

endmodule

bind waveform_moment_accumulator_unit wma_checker u_wma_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .error     (error),
  .read_data (read_data)
);

@@ test/tb_top.sv @@
// Self-checking testbench for waveform_moment_accumulator_unit.
// Depends on wma_pkg and on the RTL of the block; nothing else.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  // The command code that the block ignores.
  localparam logic [wma_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One beat on the command side of the block.
  typedef struct {
    logic [wma_pkg::CMD_W-1:0]     cmd;
    logic [wma_pkg::CHANNEL_W-1:0] ch;
    logic [wma_pkg::INDEX_W-1:0]   si;
    logic [wma_pkg::VALUE_W-1:0]   val;
    logic [wma_pkg::KIND_W-1:0]    kind;
    logic [wma_pkg::INDEX_W-1:0]   sj;
  } beat_t;

  // What one read is expected to return.
  typedef struct {
    logic [wma_pkg::DATA_W-1:0] data;
    logic                       err;
  } reading_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [wma_pkg::CMD_W-1:0]     command;
  logic [wma_pkg::CHANNEL_W-1:0] channel;
  logic [wma_pkg::INDEX_W-1:0]   sample_index;
  logic [wma_pkg::VALUE_W-1:0]   sample_value;
  logic [wma_pkg::KIND_W-1:0]    stat_kind;
  logic [wma_pkg::INDEX_W-1:0]   second_index;
  logic                          cfg_write;
  logic [wma_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [wma_pkg::CFG_DAT_W-1:0] cfg_data;
  logic                          done;
  logic [wma_pkg::DATA_W-1:0]    read_data;
  logic                          error;

  waveform_moment_accumulator_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .channel(channel), .sample_index(sample_index),
    .sample_value(sample_value), .stat_kind(stat_kind),
    .second_index(second_index), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .read_data(read_data), .error(error)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Shadow copy of the block's stores. They are kept sparse: an entry that
  // is missing reads as zero, which matches the cleared state.
  logic [wma_pkg::DATA_W-1:0]  shadow_counts[int];
  logic [wma_pkg::DATA_W-1:0]  shadow_sums[int];
  logic [wma_pkg::DATA_W-1:0]  shadow_squares[int];
  logic [wma_pkg::DATA_W-1:0]  shadow_pairs[int];
  logic [wma_pkg::VALUE_W-1:0] shadow_wave[64];
  // Buffer positions written since the last clear. Products must never
  // use a position that has not been written.
  logic [63:0]                 wave_written;

  logic [wma_pkg::SCOUNT_W-1:0] cfg_samples;
  logic [wma_pkg::CCOUNT_W-1:0] cfg_channels;
  logic                         cfg_cov;

  reading_t pending_reads[$];
  int       fail_count;
  int       idle_pct;

  // State of the well-formed waveform that the random part is sending.
  int wave_ch;
  int wave_pos;

  function automatic int used_samples();
    return (cfg_samples > 64) ? 64 : int'(cfg_samples);
  endfunction

  function automatic int used_channels();
    return (cfg_channels > 256) ? 256 : int'(cfg_channels);
  endfunction

  // Applies one accepted beat to the shadow stores and queues the answer
  // of a read.
  task automatic update_statistics(input beat_t b);
    int       ns;
    int       nc;
    int       key;
    reading_t r;
    logic [wma_pkg::DATA_W-1:0] prod;
    ns = used_samples();
    nc = used_channels();
    if (b.cmd == wma_pkg::CMD_ACCUMULATE) begin
      if (b.ch < nc && b.si < ns) begin
        key = b.ch * 64 + b.si;
        shadow_sums[key] = (shadow_sums.exists(key) ? shadow_sums[key] : 64'd0)
                           + 64'(b.val);
        shadow_squares[key] = (shadow_squares.exists(key) ? shadow_squares[key] : 64'd0)
                              + 64'(b.val) * 64'(b.val);
        if (cfg_cov) begin
          for (int j = 0; j < b.si; j++) begin
            key = b.ch * 4096 + j * 64 + b.si;
            prod = 64'(shadow_wave[j]) * 64'(b.val);
            shadow_pairs[key] = (shadow_pairs.exists(key) ? shadow_pairs[key] : 64'd0)
                                + prod;
          end
        end
        shadow_wave[b.si] = b.val;
        wave_written[b.si] = 1'b1;
        if (b.si == ns - 1)
          shadow_counts[b.ch] = (shadow_counts.exists(b.ch) ? shadow_counts[b.ch] : 64'd0)
                                + 64'd1;
      end
    end else if (b.cmd == wma_pkg::CMD_CLEAR) begin
      shadow_counts.delete();
      shadow_sums.delete();
      shadow_squares.delete();
      shadow_pairs.delete();
      wave_written = '0;
    end else if (b.cmd == wma_pkg::CMD_READ) begin
      r.data = '0;
      r.err  = 1'b0;
      if (b.ch >= nc) begin
        r.err = 1'b1;
      end else if (b.kind == wma_pkg::KIND_COUNT) begin
        r.data = shadow_counts.exists(b.ch) ? shadow_counts[b.ch] : 64'd0;
      end else if (b.kind == wma_pkg::KIND_PAIR) begin
        key = b.ch * 4096 + b.si * 64 + b.sj;
        if (b.si < b.sj && b.sj < ns)
          r.data = shadow_pairs.exists(key) ? shadow_pairs[key] : 64'd0;
        else
          r.err = 1'b1;
      end else if (b.si >= ns) begin
        r.err = 1'b1;
      end else begin
        key = b.ch * 64 + b.si;
        if (b.kind == wma_pkg::KIND_SUM)
          r.data = shadow_sums.exists(key) ? shadow_sums[key] : 64'd0;
        else
          r.data = shadow_squares.exists(key) ? shadow_squares[key] : 64'd0;
      end
      pending_reads.push_back(r);
    end
  endtask

  // Sends one beat and waits for the block to take it. Start is left high
  // so that a following beat can go out on the next cycle; a random gap
  // lowers it for a while.
  task automatic send_beat(input beat_t b);
    command      <= b.cmd;
    channel      <= b.ch;
    sample_index <= b.si;
    sample_value <= b.val;
    stat_kind    <= b.kind;
    second_index <= b.sj;
    start        <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    update_statistics(b);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Lowers start, then waits for every read to be answered and for the
  // longest operation to drain, so that registers may be written.
  task automatic wait_quiet();
    @(posedge clk);
    start <= 1'b0;
    while (pending_reads.size() != 0 || busy) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_register(input logic [wma_pkg::CFG_IDX_W-1:0] idx,
                                input logic [wma_pkg::CFG_DAT_W-1:0] value);
    wait_quiet();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == wma_pkg::CFG_SAMPLE_COUNT) cfg_samples = value[wma_pkg::SCOUNT_W-1:0];
    else if (idx == wma_pkg::CFG_CHANNEL_COUNT) cfg_channels = value[wma_pkg::CCOUNT_W-1:0];
    else if (idx == wma_pkg::CFG_COV_ENABLE) cfg_cov = value[0];
  endtask

  function automatic beat_t mk(input logic [wma_pkg::CMD_W-1:0] cmd, input int ch,
                               input int si, input int val,
                               input logic [wma_pkg::KIND_W-1:0] kind, input int sj);
    beat_t b;
    b.cmd  = cmd;
    b.ch   = ch[wma_pkg::CHANNEL_W-1:0];
    b.si   = si[wma_pkg::INDEX_W-1:0];
    b.val  = val[wma_pkg::VALUE_W-1:0];
    b.kind = kind;
    b.sj   = sj[wma_pkg::INDEX_W-1:0];
    return b;
  endfunction

  // Every result is compared with the oldest expectation as it appears.
  always @(posedge clk) begin
    reading_t exp_r;
    if (!rst && done) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result beat: read_data %h error %b", read_data, error);
        fail_count++;
      end else begin
        exp_r = pending_reads.pop_front();
        if (read_data !== exp_r.data) begin
          $error("read_data: expected %h, got %h", exp_r.data, read_data);
          fail_count++;
        end
        if (error !== exp_r.err) begin
          $error("error: expected %b, got %b", exp_r.err, error);
          fail_count++;
        end
      end
    end
  end

  // Extremes of the fields, every command and each named special case.
  task automatic test_directed();
    idle_pct = 0;
    send_beat(mk(wma_pkg::CMD_READ, 0, 0, 0, wma_pkg::KIND_COUNT, 0));
    send_beat(mk(wma_pkg::CMD_READ, 255, 63, 0, wma_pkg::KIND_SUM, 0));
    send_beat(mk(wma_pkg::CMD_READ, 0, 0, 0, wma_pkg::KIND_PAIR, 63));
    send_beat(mk(wma_pkg::CMD_READ, 0, 5, 0, wma_pkg::KIND_PAIR, 5));
    // The unused command code is ignored.
    send_beat(mk(CMD_UNUSED, 255, 63, 65535, wma_pkg::KIND_PAIR, 63));
    write_register(wma_pkg::CFG_SAMPLE_COUNT, 9'd4);
    write_register(wma_pkg::CFG_COV_ENABLE, 9'd1);
    send_beat(mk(wma_pkg::CMD_ACCUMULATE, 0, 0, 65535, wma_pkg::KIND_COUNT, 0));
    send_beat(mk(wma_pkg::CMD_ACCUMULATE, 0, 1, 65535, wma_pkg::KIND_COUNT, 0));
    send_beat(mk(wma_pkg::CMD_ACCUMULATE, 0, 2, 0, wma_pkg::KIND_COUNT, 0));
    send_beat(mk(wma_pkg::CMD_ACCUMULATE, 0, 3, 4660, wma_pkg::KIND_COUNT, 0));
    // A sample position beyond the waveform length is dropped.
    send_beat(mk(wma_pkg::CMD_ACCUMULATE, 0, 4, 777, wma_pkg::KIND_COUNT, 0));
    send_beat(mk(wma_pkg::CMD_READ, 0, 63, 0, wma_pkg::KIND_COUNT, 0));
    send_beat(mk(wma_pkg::CMD_READ, 0, 0, 0, wma_pkg::KIND_SUM, 0));
    send_beat(mk(wma_pkg::CMD_READ, 0, 1, 0, wma_pkg::KIND_SUMSQ, 0));
    send_beat(mk(wma_pkg::CMD_READ, 0, 0, 0, wma_pkg::KIND_PAIR, 1));
    send_beat(mk(wma_pkg::CMD_READ, 0, 1, 0, wma_pkg::KIND_PAIR, 3));
    send_beat(mk(wma_pkg::CMD_READ, 0, 1, 0, wma_pkg::KIND_PAIR, 0));
    send_beat(mk(wma_pkg::CMD_READ, 0, 2, 0, wma_pkg::KIND_PAIR, 4));
    send_beat(mk(wma_pkg::CMD_READ, 0, 4, 0, wma_pkg::KIND_SUM, 0));
    write_register(wma_pkg::CFG_CHANNEL_COUNT, 9'd1);
    // Channels past the configured count are errors, and dropped samples.
    send_beat(mk(wma_pkg::CMD_READ, 1, 0, 0, wma_pkg::KIND_COUNT, 0));
    send_beat(mk(wma_pkg::CMD_ACCUMULATE, 255, 0, 100, wma_pkg::KIND_COUNT, 0));
    send_beat(mk(wma_pkg::CMD_CLEAR, 0, 0, 0, wma_pkg::KIND_COUNT, 0));
    send_beat(mk(wma_pkg::CMD_READ, 0, 0, 0, wma_pkg::KIND_SUM, 0));
    send_beat(mk(wma_pkg::CMD_READ, 0, 0, 0, wma_pkg::KIND_COUNT, 0));
    wait_quiet();
  endtask

  // Mostly well-formed waveforms with random values, mixed with reads of
  // every kind and with noise beats that hit the range checks.
  task automatic test_random_phase(input int samples, input int channels,
                                   input int cov, input int beats, input int pct);
    beat_t b;
    int    ns;
    int    nc;
    int    r;
    int    sent;
    int    pick;
    write_register(wma_pkg::CFG_SAMPLE_COUNT, samples[wma_pkg::CFG_DAT_W-1:0]);
    write_register(wma_pkg::CFG_CHANNEL_COUNT, channels[wma_pkg::CFG_DAT_W-1:0]);
    write_register(wma_pkg::CFG_COV_ENABLE, cov[wma_pkg::CFG_DAT_W-1:0]);
    idle_pct = pct;
    ns = used_samples();
    nc = used_channels();
    wave_pos = 0;
    wave_ch = (nc > 0) ? $urandom_range(nc - 1) : 0;
    sent = 0;
    while (sent < beats) begin
      r = $urandom_range(99);
      b = mk($urandom_range(2) == 1 ? wma_pkg::CMD_READ : wma_pkg::CMD_ACCUMULATE,
             $urandom_range(255), $urandom_range(63), $urandom_range(65535),
             $urandom_range(3), $urandom_range(63));
      if (r < 60 && ns > 0 && nc > 0) begin
        b.cmd = wma_pkg::CMD_ACCUMULATE;
        b.ch  = wave_ch[wma_pkg::CHANNEL_W-1:0];
        b.si  = wave_pos[wma_pkg::INDEX_W-1:0];
        wave_pos++;
        // A waveform is sometimes cut short and another channel begins.
        if (wave_pos >= ns || $urandom_range(99) < 3) begin
          wave_pos = 0;
          wave_ch = $urandom_range(nc - 1);
        end
      end else if (r < 88) begin
        b.cmd = wma_pkg::CMD_READ;
        if (nc > 0 && $urandom_range(3) != 0) begin
          pick = $urandom_range(nc - 1);
          b.ch = pick[wma_pkg::CHANNEL_W-1:0];
        end
        if (ns > 0 && $urandom_range(3) != 0) begin
          pick = $urandom_range(ns - 1);
          b.si = pick[wma_pkg::INDEX_W-1:0];
          pick = $urandom_range(ns - 1);
          b.sj = pick[wma_pkg::INDEX_W-1:0];
        end
        if (b.kind == wma_pkg::KIND_PAIR && $urandom_range(1) == 1 && b.si > b.sj) begin
          b.si = b.sj;
          pick = int'(b.si) + $urandom_range(ns > 1 ? 1 : 0);
          b.sj = pick[wma_pkg::INDEX_W-1:0];
        end
      end else if (r < 97) begin
        b.cmd = wma_pkg::CMD_ACCUMULATE;
      end else begin
        b.cmd = CMD_UNUSED;
      end
      // Never let a product pick up a buffer position not yet written.
      if (b.cmd == wma_pkg::CMD_ACCUMULATE && cfg_cov && b.ch < nc && b.si < ns) begin
        for (int j = 0; j < b.si; j++) begin
          if (!wave_written[j]) begin
            b.si = j[wma_pkg::INDEX_W-1:0];
            break;
          end
        end
      end
      send_beat(b);
      if (b.cmd != CMD_UNUSED) sent++;
    end
    wait_quiet();
  endtask

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    command      <= wma_pkg::CMD_ACCUMULATE;
    channel      <= '0;
    sample_index <= '0;
    sample_value <= '0;
    stat_kind    <= wma_pkg::KIND_COUNT;
    second_index <= '0;
    cfg_write    <= 1'b0;
    cfg_index    <= wma_pkg::CFG_SAMPLE_COUNT;
    cfg_data     <= '0;
    fail_count   = 0;
    idle_pct     = 0;
    cfg_samples  = wma_pkg::SAMPLE_COUNT_RESET;
    cfg_channels = wma_pkg::CHANNEL_COUNT_RESET;
    cfg_cov      = 1'b0;
    wave_written = '0;
    foreach (shadow_wave[k]) shadow_wave[k] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_phase(64, 256, 1, 350, 0);
    test_random_phase(4, 16, 1, 350, 66);
    test_random_phase(1, 1, 1, 100, 11);
    test_random_phase(127, 511, 0, 250, 0);
    test_random_phase(0, 3, 1, 60, 66);
    test_random_phase(7, 0, 1, 60, 11);
    test_random_phase(20, 300, 1, 300, 0);

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Two clearing passes, one after reset and one for the clear command, dominate
  // the run; this bound leaves ample room above them.
  initial begin
    #(12.0 * 4000000);
    $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
design/wma_pkg.sv
design/wma_ctrl.sv
design/wma_datapath.sv
design/waveform_moment_accumulator_unit.sv
design/wma_checker.sv
test/tb_top.sv
